// File: rtl/can_signal_decode_average_assert.svh
// assertion macros used by the can signal decoder datapath
`ifndef CAN_SIGNAL_DECODE_AVERAGE_ASSERT_SVH
`define CAN_SIGNAL_DECODE_AVERAGE_ASSERT_SVH

// same-cycle implication, checked on every edge outside reset
`define CSDA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CSDA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/csda_pkg.sv
// shared types and constants of the can signal decoder
package csda_pkg;

  localparam int ID_W       = 29;
  localparam int DATA_W     = 64;
  localparam int NAME_W     = 11;
  localparam int POS_W      = 6;
  localparam int SCL_W      = 24;
  localparam int CNT_W      = 4;
  localparam int BASE_W     = 9;
  localparam int WIN_W      = 16;
  localparam int SUM_W      = 32;
  localparam int FC_W       = 16;
  localparam int DVD_W      = 64;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int LAY_W      = NAME_W + 2 * POS_W + 1;
  localparam int SCALE_W    = 2 * SCL_W;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_AVG_WINDOW  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HASH_MULT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_DIV   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_DIV  = 3'd3;

  typedef enum logic [1:0] {
    FUNC_CLEAR    = 2'd0,
    FUNC_LOAD_MSG = 2'd1,
    FUNC_LOAD_SIG = 2'd2,
    FUNC_FRAME    = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    DIV_SCALE  = 2'd0,
    DIV_OFFSET = 2'd1,
    DIV_AVG    = 2'd2
  } div_sel_t;

  typedef struct packed {
    logic     clear_all;
    logic     def_write;
    logic     hash_mul;
    logic     slot_load;
    logic     frame_inc;
    logic     sig_read;
    logic     sig_ext;
    logic     sig_mul;
    logic     div_start;
    div_sel_t div_sel;
    logic     latch_t;
    logic     sum_write;
    logic     win_inc;
    logic     win_clr;
    logic     fc_clr;
    logic     push;
    logic     push_last;
  } cmd_t;

  typedef struct packed {
    func_t func;
    logic  id_zero;
    logic  slot_empty;
    logic  slot_match;
    logic  fc_zero;
    logic  sig_more;
    logic  div_done;
    logic  win_hit;
    logic  out_free;
    logic  pend_vld;
  } status_t;

endpackage

// File: rtl/can_signal_decode_average.sv
// top level of the can signal decoder with windowed averaging
// usage:
//   input channel in_*: one item per transfer (clear, load message, load signal
//   definition or can frame); in_stall is high while an item is being worked on.
//   result channel out_*: flush results only, one per averaged signal, out_last
//   marks the final result of a flush; the block never drops a held result.
//   cfg_*: plain write port, writes take effect at once; write only while idle, the block does not enforce it.
// sequencing, built around the shared 64-step serial divider:
//   clear or load definition: dispatch only; load message: hash, then probe slots
//   in turn. frame: the same lookup, then two divisions per decoded signal and
//   an update of the window count.
//   flush: one division per reported signal, and it waits on out_stall.
// reset (rst_n low, synchronous) empties the slot table, sums and window count
// and loads the register defaults; definition memories stay as they are.
// a stall on the result side holds one result in the output register and one
// more in a pending register; the flush then waits, new items are not taken.
module can_signal_decode_average #(
  parameter int SLOTS               = 8,
  parameter int SIGNALS_PER_MESSAGE = 8,
  parameter int DEFINITION_DEPTH    = 512
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        in_func,
  input  logic [csda_pkg::BASE_W-1:0]       in_table_index,
  input  logic [csda_pkg::ID_W-1:0]         in_can_id,
  input  logic [csda_pkg::DATA_W-1:0]       in_frame_data,
  input  logic [csda_pkg::CNT_W-1:0]        in_signal_count,
  input  logic [csda_pkg::BASE_W-1:0]       in_signal_base,
  input  logic [csda_pkg::NAME_W-1:0]       in_name_index,
  input  logic [csda_pkg::POS_W-1:0]        in_start_bit,
  input  logic [csda_pkg::POS_W-1:0]        in_bit_length,
  input  logic                              in_is_signed,
  input  logic [csda_pkg::SCL_W-1:0]        in_scale,
  input  logic [csda_pkg::SCL_W-1:0]        in_offset,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [csda_pkg::NAME_W-1:0]       out_signal_id,
  output logic signed [csda_pkg::SUM_W-1:0] out_average_value,
  output logic                              out_last,
  input  logic                              cfg_we,
  input  logic [csda_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [csda_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import csda_pkg::*;

  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  cmd_t              cmd;
  status_t           st;
  logic [SLOT_W-1:0] cmd_slot;
  logic [CNT_W-1:0]  cmd_sig;
  logic [SLOT_W-1:0] hash_slot;
  logic              in_accept;

  // an item transfers only when the controller is idle
  assign in_accept = in_valid && !in_stall;

  csda_ctrl #(
    .SLOTS (SLOTS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .st        (st),
    .hash_slot (hash_slot),
    .cmd       (cmd),
    .cmd_slot  (cmd_slot),
    .cmd_sig   (cmd_sig)
  );

  // tables, memories, arithmetic and the result registers
  csda_dp #(
    .SLOTS (SLOTS),
    .SPM   (SIGNALS_PER_MESSAGE),
    .DEPTH (DEFINITION_DEPTH)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_accept         (in_accept),
    .in_func           (in_func),
    .in_table_index    (in_table_index),
    .in_can_id         (in_can_id),
    .in_frame_data     (in_frame_data),
    .in_signal_count   (in_signal_count),
    .in_signal_base    (in_signal_base),
    .in_name_index     (in_name_index),
    .in_start_bit      (in_start_bit),
    .in_bit_length     (in_bit_length),
    .in_is_signed      (in_is_signed),
    .in_scale          (in_scale),
    .in_offset         (in_offset),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .cmd               (cmd),
    .cmd_slot          (cmd_slot),
    .cmd_sig           (cmd_sig),
    .st                (st),
    .hash_slot         (hash_slot),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_signal_id     (out_signal_id),
    .out_average_value (out_average_value),
    .out_last          (out_last)
  );
endmodule

// File: rtl/csda_div.sv
// restoring divider, one quotient bit per cycle
module csda_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [csda_pkg::DVD_W-1:0]  dividend,
  input  logic [csda_pkg::SCL_W-1:0]  divisor,
  output logic                        busy,
  output logic                        done,
  output logic [csda_pkg::DVD_W-1:0]  quot
);
  import csda_pkg::*;

  localparam int CW = $clog2(DVD_W);

  logic [CW-1:0]    cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DVD_W-1:0] q_r;
  logic [SCL_W-1:0] r_r;
  logic [SCL_W-1:0] d_r;
  logic [SCL_W:0]   part;
  logic [SCL_W+1:0] diff;
  logic             ge;

  assign part = {r_r, q_r[DVD_W-1]};
  assign diff = {1'b0, part} - {2'b00, d_r};
  assign ge   = !diff[SCL_W+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(DVD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r <= dividend;
      r_r <= '0;
      d_r <= divisor;
    end else if (busy_r) begin
      q_r <= {q_r[DVD_W-2:0], ge};
      r_r <= ge ? diff[SCL_W-1:0] : part[SCL_W-1:0];
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quot = q_r;
endmodule

// File: rtl/csda_dp.sv
// datapath: tables, definition memories, sum memory, decode math and result registers
`include "can_signal_decode_average_assert.svh"
module csda_dp #(
  parameter int  SLOTS    = 8,
  parameter int  SPM      = 8,
  parameter int  DEPTH    = 512,
  localparam int SLOT_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_accept,
  input  logic [1:0]                      in_func,
  input  logic [csda_pkg::BASE_W-1:0]     in_table_index,
  input  logic [csda_pkg::ID_W-1:0]       in_can_id,
  input  logic [csda_pkg::DATA_W-1:0]     in_frame_data,
  input  logic [csda_pkg::CNT_W-1:0]      in_signal_count,
  input  logic [csda_pkg::BASE_W-1:0]     in_signal_base,
  input  logic [csda_pkg::NAME_W-1:0]     in_name_index,
  input  logic [csda_pkg::POS_W-1:0]      in_start_bit,
  input  logic [csda_pkg::POS_W-1:0]      in_bit_length,
  input  logic                            in_is_signed,
  input  logic [csda_pkg::SCL_W-1:0]      in_scale,
  input  logic [csda_pkg::SCL_W-1:0]      in_offset,
  input  logic                            cfg_we,
  input  logic [csda_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [csda_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  csda_pkg::cmd_t                  cmd,
  input  logic [SLOT_W-1:0]               cmd_slot,
  input  logic [csda_pkg::CNT_W-1:0]      cmd_sig,
  output csda_pkg::status_t               st,
  output logic [SLOT_W-1:0]               hash_slot,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [csda_pkg::NAME_W-1:0]     out_signal_id,
  output logic signed [csda_pkg::SUM_W-1:0] out_average_value,
  output logic                            out_last
);
  import csda_pkg::*;

  localparam int SUMS   = SLOTS * SPM;
  localparam int SUM_AW = (SUMS > 1) ? $clog2(SUMS) : 1;
  localparam int DEF_AW = $clog2(DEPTH);
  localparam int HP_W   = ID_W + WIN_W;

  // definition address modulo the store depth, by conditional subtraction
  function automatic logic [DEF_AW-1:0] def_mod(input logic [9:0] v);
    logic [9:0] r;
    r = v;
    for (int i = 9; i >= 0; i--) begin
      if (longint'(r) >= (longint'(DEPTH) << i)) r = r - 10'(DEPTH << i);
    end
    return DEF_AW'(r);
  endfunction

  // hash product modulo the slot count: fold octal digits by their
  // constant weights 8^i mod SLOTS, then reduce by conditional subtraction
  function automatic logic [SLOT_W-1:0] slot_mod(input logic [HP_W-1:0] x);
    logic [11:0] acc;
    int          pw;
    acc = '0;
    pw  = 1 % SLOTS;
    for (int i = 0; i < HP_W / 3; i++) begin
      acc = acc + 12'(x[3*i +: 3]) * 12'(pw);
      pw  = (pw * 8) % SLOTS;
    end
    for (int i = 7; i >= 0; i--) begin
      if (acc >= 12'(SLOTS << i)) acc = acc - 12'(SLOTS << i);
    end
    return SLOT_W'(acc);
  endfunction

  // configuration
  logic [WIN_W-1:0] aw_r;
  logic [WIN_W-1:0] hm_r;
  logic [SCL_W-1:0] sd_r;
  logic [SCL_W-1:0] od_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      aw_r <= WIN_W'(100);
      hm_r <= WIN_W'(31);
      sd_r <= SCL_W'(1000);
      od_r <= SCL_W'(1000);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_AVG_WINDOW: aw_r <= cfg_wdata[WIN_W-1:0];
        CFG_HASH_MULT:  hm_r <= cfg_wdata[WIN_W-1:0];
        CFG_SCALE_DIV:  sd_r <= cfg_wdata;
        CFG_OFFSET_DIV: od_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // captured item
  func_t             func_r;
  logic [BASE_W-1:0] tidx_r;
  logic [ID_W-1:0]   id_r;
  logic [DATA_W-1:0] data_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [BASE_W-1:0] base_r;
  logic [LAY_W-1:0]  lay_in_r;
  logic [SCALE_W-1:0] scl_in_r;

  always_ff @(posedge clk) begin
    if (in_accept) begin
      func_r   <= func_t'(in_func);
      tidx_r   <= in_table_index;
      id_r     <= in_can_id;
      data_r   <= in_frame_data;
      cnt_r    <= in_signal_count;
      base_r   <= in_signal_base;
      lay_in_r <= {in_name_index, in_start_bit, in_bit_length, in_is_signed};
      scl_in_r <= {in_scale, in_offset};
    end
  end

  // slot table
  logic [ID_W-1:0]   sid_r   [SLOTS];
  logic [CNT_W-1:0]  scnt_r  [SLOTS];
  logic [BASE_W-1:0] sbase_r [SLOTS];
  logic [FC_W-1:0]   sfc_r   [SLOTS];

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear_all) begin
      for (int i = 0; i < SLOTS; i++) begin
        sid_r[i]   <= '0;
        scnt_r[i]  <= '0;
        sbase_r[i] <= '0;
        sfc_r[i]   <= '0;
      end
    end else begin
      if (cmd.slot_load) begin
        sid_r[cmd_slot]   <= id_r;
        scnt_r[cmd_slot]  <= (cnt_r > CNT_W'(SPM)) ? CNT_W'(SPM) : cnt_r;
        sbase_r[cmd_slot] <= base_r;
        sfc_r[cmd_slot]   <= '0;
      end
      if (cmd.frame_inc) sfc_r[cmd_slot] <= sfc_r[cmd_slot] + 1'b1;
      if (cmd.fc_clr)    sfc_r[cmd_slot] <= '0;
    end
  end

  // definition stores
  logic [LAY_W-1:0]   lay_mem [DEPTH];
  logic [SCALE_W-1:0] scl_mem [DEPTH];
  logic [LAY_W-1:0]   lay_q_r;
  logic [SCALE_W-1:0] scl_q_r;
  logic [DEF_AW-1:0]  def_waddr;
  logic [DEF_AW-1:0]  def_raddr;

  assign def_waddr = def_mod({1'b0, tidx_r});
  assign def_raddr = def_mod({1'b0, sbase_r[cmd_slot]} + 10'(cmd_sig) + 10'd1);

  always_ff @(posedge clk) begin
    if (cmd.def_write) begin
      lay_mem[def_waddr] <= lay_in_r;
      scl_mem[def_waddr] <= scl_in_r;
    end
    if (cmd.sig_read) begin
      lay_q_r <= lay_mem[def_raddr];
      scl_q_r <= scl_mem[def_raddr];
    end
  end

  // sum memory, entries not valid read as zero
  logic [SUM_W-1:0]  sum_mem [SUMS];
  logic [SUMS-1:0]   sum_vld_r;
  logic [SUM_W-1:0]  sum_q_r;
  logic              sum_qv_r;
  logic [SUM_AW-1:0] sidx;
  logic [SUM_W-1:0]  sum_eff;
  logic [SUM_W-1:0]  t_r;
  logic [SUM_W-1:0]  sum_nxt;
  logic [DVD_W-1:0]  div_q;

  assign sidx    = SUM_AW'(int'(cmd_slot) * SPM + int'(cmd_sig));
  assign sum_eff = sum_qv_r ? sum_q_r : '0;
  assign sum_nxt = sum_eff + t_r + div_q[SUM_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.sig_read) begin
      sum_q_r  <= sum_mem[sidx];
      sum_qv_r <= sum_vld_r[sidx];
    end
    if (cmd.sum_write) sum_mem[sidx] <= sum_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear_all) begin
      sum_vld_r <= '0;
    end else begin
      if (cmd.slot_load) begin
        for (int j = 0; j < SPM; j++) sum_vld_r[SUM_AW'(int'(cmd_slot) * SPM + j)] <= 1'b0;
      end
      if (cmd.sum_write) sum_vld_r[sidx] <= 1'b1;
      if (cmd.push)      sum_vld_r[sidx] <= 1'b0;
    end
  end

  // field extraction, msb first
  logic [POS_W-1:0]    f_start;
  logic [POS_W-1:0]    f_len;
  logic [POS_W-1:0]    len_e;
  logic                fits;
  logic [DATA_W-1:0]   shifted;
  logic [SUM_W-1:0]    top;
  logic [SUM_W-1:0]    raw_f;
  logic                v_neg;
  logic signed [SUM_W:0] v_nxt;
  logic signed [SUM_W:0] v_r;
  logic signed [57:0]  prod_r;

  assign f_start = lay_q_r[2*POS_W:POS_W+1];
  assign f_len   = lay_q_r[POS_W:1];
  assign len_e   = (f_len > POS_W'(32)) ? POS_W'(32) : f_len;
  assign fits    = (len_e != '0) && ((7'(f_start) + 7'(len_e)) <= 7'd64);
  assign shifted = data_r << f_start;
  assign top     = shifted[DATA_W-1:DATA_W-SUM_W];
  assign raw_f   = fits ? (top >> (POS_W'(32) - len_e)) : '0;
  assign v_neg   = lay_q_r[0] && fits && top[SUM_W-1];
  assign v_nxt   = $signed({1'b0, raw_f} - (v_neg ? (33'd1 << len_e) : 33'd0));

  always_ff @(posedge clk) begin
    if (cmd.sig_ext) v_r <= v_nxt;
    if (cmd.sig_mul) prod_r <= v_r * $signed({1'b0, scl_q_r[SCALE_W-1:SCL_W]});
  end

  // hash product
  logic [HP_W-1:0] hash_prod_r;
  always_ff @(posedge clk) begin
    if (cmd.hash_mul) hash_prod_r <= id_r * hm_r;
  end

  // shared divider operand select
  logic [DVD_W-1:0] dvd;
  logic [SCL_W-1:0] dvs;
  logic             dneg;
  logic             neg_r;
  logic             div_busy;
  logic             div_done;
  logic [57:0]      pmag;
  logic [SUM_W-1:0] smag;
  logic [SUM_W-1:0] sq32;

  assign pmag = prod_r[57] ? (58'd0 - $unsigned(prod_r)) : $unsigned(prod_r);
  assign smag = sum_eff[SUM_W-1] ? (32'd0 - sum_eff) : sum_eff;

  always_comb begin
    unique case (cmd.div_sel)
      DIV_SCALE: begin
        dvd  = DVD_W'(pmag);
        dvs  = (sd_r == '0) ? SCL_W'(1) : sd_r;
        dneg = prod_r[57];
      end
      DIV_OFFSET: begin
        dvd  = DVD_W'(scl_q_r[SCL_W-1:0]);
        dvs  = (od_r == '0) ? SCL_W'(1) : od_r;
        dneg = 1'b0;
      end
      // average of a flushed sum
      default: begin
        dvd  = DVD_W'(smag);
        dvs  = SCL_W'(sfc_r[cmd_slot]);
        dneg = sum_eff[SUM_W-1];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) neg_r <= dneg;
    if (cmd.latch_t)   t_r   <= sq32;
  end

  csda_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dvd),
    .divisor  (dvs),
    .busy     (div_busy),
    .done     (div_done),
    .quot     (div_q)
  );

  assign sq32      = neg_r ? (32'd0 - div_q[SUM_W-1:0]) : div_q[SUM_W-1:0];
  assign hash_slot = slot_mod(hash_prod_r);

  // frame window
  logic [WIN_W-1:0] win_r;
  logic             win_hit;
  assign win_hit = ({1'b0, win_r} + 17'd1) >= {1'b0, aw_r};

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear_all || cmd.win_clr) win_r <= '0;
    else if (cmd.win_inc) win_r <= win_r + 1'b1;
  end

  // one result held back so the final one can carry last
  logic [NAME_W-1:0] pend_id_r;
  logic [SUM_W-1:0]  pend_val_r;
  logic              pend_vld_r;
  logic              out_valid_r;
  logic [NAME_W-1:0] out_id_r;
  logic [SUM_W-1:0]  out_val_r;
  logic              out_last_r;
  logic              out_load;

  assign out_load = (cmd.push && pend_vld_r) || cmd.push_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.push) pend_vld_r <= 1'b1;
      else if (cmd.push_last) pend_vld_r <= 1'b0;
      if (out_load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      pend_id_r  <= lay_q_r[LAY_W-1:LAY_W-NAME_W];
      pend_val_r <= sq32;
    end
    if (out_load) begin
      out_id_r   <= pend_id_r;
      out_val_r  <= pend_val_r;
      out_last_r <= cmd.push_last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_signal_id     = out_id_r;
  assign out_average_value = $signed(out_val_r);
  assign out_last          = out_last_r;

  always_comb begin
    st.func       = func_r;
    st.id_zero    = (id_r == '0);
    st.slot_empty = (sid_r[cmd_slot] == '0);
    st.slot_match = (sid_r[cmd_slot] == id_r);
    st.fc_zero    = (sfc_r[cmd_slot] == '0);
    st.sig_more   = (cmd_sig < scnt_r[cmd_slot]);
    st.div_done   = div_done;
    st.win_hit    = win_hit;
    st.out_free   = !out_valid_r || !out_stall;
    st.pend_vld   = pend_vld_r;
  end

  `CSDA_ASSERT_IMP(a_push_room, cmd.push && pend_vld_r, !out_valid_r || !out_stall, "flush result overwrote a waiting transfer")
  `CSDA_ASSERT_IMP(a_div_idle, cmd.div_start, !div_busy, "divider restarted while busy")
  `CSDA_ASSERT_IMP(a_win_flush, cmd.win_clr, win_hit, "window cleared before it was full")
  `CSDA_ASSERT_NXT(a_last_drains, cmd.push_last, out_valid_r && out_last_r && !pend_vld_r, "last result not presented")
endmodule

// File: rtl/csda_ctrl.sv
// controller state machine sequencing load, decode and flush work
module csda_ctrl #(
  parameter int  SLOTS  = 8,
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  csda_pkg::status_t          st,
  input  logic [SLOT_W-1:0]          hash_slot,
  output csda_pkg::cmd_t             cmd,
  output logic [SLOT_W-1:0]          cmd_slot,
  output logic [csda_pkg::CNT_W-1:0] cmd_sig
);
  import csda_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_DISPATCH, S_HASH, S_PROBE,
    S_SIG_RD, S_SIG_EXT, S_SIG_MUL, S_SIG_DIV, S_SIG_WAIT1, S_SIG_WAIT2,
    S_WIN, S_FL_SLOT, S_FL_SIG, S_FL_DIV, S_FL_WAIT, S_FL_PUSH, S_FL_END
  } state_t;

  state_t            state_r;
  logic [SLOT_W-1:0] s_r;
  logic [SLOT_W-1:0] k_r;
  logic [CNT_W-1:0]  j_r;
  logic              s_last;
  logic [SLOT_W-1:0] s_inc;

  assign s_last = (s_r == SLOT_W'(SLOTS - 1));
  assign s_inc  = s_last ? '0 : s_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      s_r     <= '0;
      k_r     <= '0;
      j_r     <= '0;
    end else begin
      unique case (state_r)
        S_IDLE:     if (in_valid) state_r <= S_DISPATCH;
        S_DISPATCH: begin
          if (st.func == FUNC_CLEAR || st.func == FUNC_LOAD_SIG || st.id_zero)
            state_r <= S_IDLE;
          else
            state_r <= S_HASH;
        end
        S_HASH: begin
          s_r     <= hash_slot;
          k_r     <= '0;
          state_r <= S_PROBE;
        end
        S_PROBE: begin
          if (st.func == FUNC_LOAD_MSG && st.slot_empty) begin
            state_r <= S_IDLE;
          end else if (st.func == FUNC_FRAME && st.slot_match) begin
            j_r     <= '0;
            state_r <= S_SIG_RD;
          end else if (k_r == SLOT_W'(SLOTS - 1)) begin
            state_r <= S_IDLE;
          end else begin
            s_r <= s_inc;
            k_r <= k_r + 1'b1;
          end
        end
        S_SIG_RD:    state_r <= st.sig_more ? S_SIG_EXT : S_WIN;
        S_SIG_EXT:   state_r <= S_SIG_MUL;
        S_SIG_MUL:   state_r <= S_SIG_DIV;
        S_SIG_DIV:   state_r <= S_SIG_WAIT1;
        S_SIG_WAIT1: if (st.div_done) state_r <= S_SIG_WAIT2;
        S_SIG_WAIT2: begin
          if (st.div_done) begin
            j_r     <= j_r + 1'b1;
            state_r <= S_SIG_RD;
          end
        end
        S_WIN: begin
          if (st.win_hit) begin
            s_r     <= '0;
            state_r <= S_FL_SLOT;
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_FL_SLOT: begin
          if (!st.fc_zero) begin
            j_r     <= '0;
            state_r <= S_FL_SIG;
          end else if (s_last) begin
            state_r <= S_FL_END;
          end else begin
            s_r <= s_inc;
          end
        end
        S_FL_SIG: begin
          if (st.sig_more) begin
            state_r <= S_FL_DIV;
          end else if (s_last) begin
            state_r <= S_FL_END;
          end else begin
            s_r     <= s_inc;
            state_r <= S_FL_SLOT;
          end
        end
        S_FL_DIV:  state_r <= S_FL_WAIT;
        S_FL_WAIT: if (st.div_done) state_r <= S_FL_PUSH;
        S_FL_PUSH: begin
          if (!st.pend_vld || st.out_free) begin
            j_r     <= j_r + 1'b1;
            state_r <= S_FL_SIG;
          end
        end
        S_FL_END: if (!st.pend_vld || st.out_free) state_r <= S_IDLE;
        default:  state_r <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd = '0;
    unique case (state_r)
      S_DISPATCH: begin
        cmd.clear_all = (st.func == FUNC_CLEAR);
        cmd.def_write = (st.func == FUNC_LOAD_SIG);
        cmd.hash_mul  = 1'b1;
      end
      S_PROBE: begin
        cmd.slot_load = (st.func == FUNC_LOAD_MSG) && st.slot_empty;
        cmd.frame_inc = (st.func == FUNC_FRAME) && st.slot_match;
      end
      S_SIG_RD:  cmd.sig_read = st.sig_more;
      S_SIG_EXT: cmd.sig_ext  = 1'b1;
      S_SIG_MUL: cmd.sig_mul  = 1'b1;
      S_SIG_DIV: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_SCALE;
      end
      S_SIG_WAIT1: begin
        cmd.latch_t   = st.div_done;
        cmd.div_start = st.div_done;
        cmd.div_sel   = DIV_OFFSET;
      end
      S_SIG_WAIT2: cmd.sum_write = st.div_done;
      S_WIN: begin
        cmd.win_clr = st.win_hit;
        cmd.win_inc = !st.win_hit;
      end
      S_FL_SIG: begin
        cmd.sig_read = st.sig_more;
        cmd.fc_clr   = !st.sig_more;
      end
      S_FL_DIV: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_AVG;
      end
      S_FL_PUSH: cmd.push      = !st.pend_vld || st.out_free;
      S_FL_END:  cmd.push_last = st.pend_vld && st.out_free;
      default: ;
    endcase
  end

  assign in_stall = (state_r != S_IDLE);
  assign cmd_slot = s_r;
  assign cmd_sig  = j_r;
endmodule

// File: tb/tb_can_signal_decode_average.sv
// testbench of the can signal decoder with windowed averaging
`timescale 1ns / 100ps

module tb_can_signal_decode_average;
  import csda_pkg::*;

  localparam int SLOT_NUM   = 8;
  localparam int SIG_NUM    = 8;
  localparam int DEF_NUM    = 512;
  localparam int IDLE_LIMIT = 20000; // cycles without any transfer
  localparam int SETTLE     = 1500;  // longest silent frame plus margin
  localparam int HOLD_LEN   = 400;

  typedef struct {
    func_t              func;
    logic [BASE_W-1:0]  tidx;
    logic [ID_W-1:0]    id;
    logic [DATA_W-1:0]  data;
    logic [CNT_W-1:0]   cnt;
    logic [BASE_W-1:0]  base;
    logic [NAME_W-1:0]  name;
    logic [POS_W-1:0]   start;
    logic [POS_W-1:0]   len;
    logic               sgn;
    logic [SCL_W-1:0]   scale;
    logic [SCL_W-1:0]   offset;
  } can_item_t;

  typedef struct {
    logic [NAME_W-1:0] name;
    logic [SUM_W-1:0]  value;
    logic              last;
  } average_t;

  // decoder state mirror and queue of averages still owed by the block
  class decode_scoreboard;
    bit [15:0] window_len, hash_mult;
    bit [23:0] scale_div, offset_div;
    bit [ID_W-1:0]   slot_id[SLOT_NUM];
    bit [CNT_W-1:0]  slot_cnt[SLOT_NUM];
    bit [BASE_W-1:0] slot_base[SLOT_NUM];
    bit [15:0]       slot_frames[SLOT_NUM];
    bit [31:0]       slot_sum[SLOT_NUM*SIG_NUM];
    bit [23:0]       def_layout[DEF_NUM];
    bit [47:0]       def_scaling[DEF_NUM];
    bit [15:0]       frames_in_window;
    average_t        owed_averages[$];
    int              errors, checked, frames_decoded;

    function new();
      window_len = 100;
      hash_mult  = 31;
      scale_div  = 1000;
      offset_div = 1000;
      clear_all();
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_AVG_WINDOW: window_len = val[15:0];
        CFG_HASH_MULT:  hash_mult  = val[15:0];
        CFG_SCALE_DIV:  scale_div  = val;
        CFG_OFFSET_DIV: offset_div = val;
        default: ;
      endcase
    endfunction

    function void clear_all();
      foreach (slot_id[i]) begin
        slot_id[i] = 0;
        slot_cnt[i] = 0;
        slot_base[i] = 0;
        slot_frames[i] = 0;
      end
      foreach (slot_sum[i]) slot_sum[i] = 0;
      foreach (def_layout[i]) begin
        def_layout[i] = 0;
        def_scaling[i] = 0;
      end
      frames_in_window = 0;
    endfunction

    function bit [31:0] decode(logic [63:0] data, int addr);
      bit [23:0] lay;
      int st, ln;
      longint unsigned raw, od, scl, ofs;
      longint v, sd, t;
      lay = def_layout[addr];
      st  = lay[12:7];
      ln  = lay[6:1];
      scl = def_scaling[addr][47:24];
      ofs = def_scaling[addr][23:0];
      raw = 0;
      if (ln > 32) ln = 32;
      if (ln != 0 && st + ln <= 64) raw = (data >> (64 - st - ln)) & ((64'd1 << ln) - 1);
      v = longint'(raw);
      // two's complement field with its top bit set
      if (lay[0] && ln != 0 && raw[ln-1]) v = v - (64'sd1 <<< ln);
      sd = (scale_div == 0) ? 1 : longint'(scale_div);
      od = (offset_div == 0) ? 1 : longint'(offset_div);
      t  = (v * longint'(scl)) / sd + longint'(ofs / od);
      return t[31:0];
    endfunction

    function void note_item(can_item_t it);
      int h, s, slot, n, a, first;
      bit found;
      longint unsigned prod;
      longint avg;
      average_t r;
      found = 0;
      slot  = 0;
      case (it.func)
        FUNC_CLEAR: clear_all();
        FUNC_LOAD_SIG: begin
          def_layout[it.tidx]  = {it.name, it.start, it.len, it.sgn};
          def_scaling[it.tidx] = {it.scale, it.offset};
        end
        default: begin
          if (it.id == 0) return;
          prod = longint'(it.id) * longint'(hash_mult);
          h = prod % SLOT_NUM;
          if (it.func == FUNC_LOAD_MSG) begin
            for (int k = 0; k < SLOT_NUM; k++) begin
              s = (h + k) % SLOT_NUM;
              if (slot_id[s] == 0) begin
                slot_id[s]     = it.id;
                slot_cnt[s]    = (it.cnt > SIG_NUM) ? SIG_NUM : it.cnt;
                slot_base[s]   = it.base;
                slot_frames[s] = 0;
                for (int j = 0; j < SIG_NUM; j++) slot_sum[s*SIG_NUM+j] = 0;
                break;
              end
            end
            return;
          end
          for (int k = 0; k < SLOT_NUM && !found; k++) begin
            s = (h + k) % SLOT_NUM;
            if (slot_id[s] == it.id) begin
              slot = s;
              found = 1;
            end
          end
          if (!found) return;
          frames_decoded++;
          slot_frames[slot]++;
          for (int j = 0; j < slot_cnt[slot]; j++)
            slot_sum[slot*SIG_NUM+j] += decode(it.data, (slot_base[slot] + j + 1) % DEF_NUM);
          frames_in_window++;
          if (frames_in_window < window_len) return;
          frames_in_window = 0;
          first = owed_averages.size();
          for (s = 0; s < SLOT_NUM; s++) begin
            if (slot_frames[s] == 0) continue;
            for (int j = 0; j < slot_cnt[s]; j++) begin
              a = (slot_base[s] + j + 1) % DEF_NUM;
              avg = longint'(int'(slot_sum[s*SIG_NUM+j])) / longint'(slot_frames[s]);
              r.name  = def_layout[a][23:13];
              r.value = avg[31:0];
              r.last  = 0;
              owed_averages.push_back(r);
              slot_sum[s*SIG_NUM+j] = 0;
            end
            slot_frames[s] = 0;
          end
          if (owed_averages.size() > first) owed_averages[$].last = 1;
        end
      endcase
    endfunction

    function void check_result(logic [NAME_W-1:0] name, logic [SUM_W-1:0] value, logic last);
      average_t e;
      checked++;
      if (owed_averages.size() == 0) begin
        $error("unexpected result: signal_id %0d average_value %0d", name, $signed(value));
        errors++;
        return;
      end
      e = owed_averages.pop_front();
      if (name !== e.name) begin
        $error("signal_id: expected %0d, actual %0d", e.name, name);
        errors++;
      end
      if (value !== e.value) begin
        $error("average_value: expected %0d, actual %0d", $signed(e.value), $signed(value));
        errors++;
      end
      if (last !== e.last) begin
        $error("last: expected %0d, actual %0d", e.last, last);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  logic [1:0] in_func = 0;
  logic [BASE_W-1:0] in_table_index = 0;
  logic [ID_W-1:0] in_can_id = 0;
  logic [DATA_W-1:0] in_frame_data = 0;
  logic [CNT_W-1:0] in_signal_count = 0;
  logic [BASE_W-1:0] in_signal_base = 0;
  logic [NAME_W-1:0] in_name_index = 0;
  logic [POS_W-1:0] in_start_bit = 0;
  logic [POS_W-1:0] in_bit_length = 0;
  logic in_is_signed = 0;
  logic [SCL_W-1:0] in_scale = 0;
  logic [SCL_W-1:0] in_offset = 0;
  logic out_valid;
  logic out_stall = 0;
  logic [NAME_W-1:0] out_signal_id;
  logic signed [SUM_W-1:0] out_average_value;
  logic out_last;
  logic cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_index = 0;
  logic [CFG_DATA_W-1:0] cfg_wdata = 0;

  decode_scoreboard sb = new();
  bit steady = 0;            // no idling on either side
  int hold_reqs = 0, hold_seen = 0, hold_left = 0;
  int idle_cycles = 0, items_sent = 0;
  logic [ID_W-1:0] known_ids[$];

  can_signal_decode_average DUT (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // result side: random stall, plus long hold-off when asked
  always @(negedge clk) begin
    if (hold_reqs != hold_seen) begin
      hold_seen = hold_reqs;
      hold_left = HOLD_LEN;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !steady && ($urandom_range(99) < 29);
    end
  end

  // check every result transfer against the oldest owed average
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_signal_id, out_average_value, out_last);
  end

  // watchdog on transfers of either channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic can_item_t rand_item();
    can_item_t it;
    it.func   = func_t'($urandom_range(3));
    it.tidx   = $urandom;
    it.id     = $urandom;
    it.data   = {$urandom, $urandom};
    it.cnt    = $urandom;
    it.base   = $urandom;
    it.name   = $urandom;
    it.start  = $urandom;
    it.len    = $urandom;
    it.sgn    = $urandom;
    it.scale  = $urandom;
    it.offset = $urandom;
    return it;
  endfunction

  // one input transfer, with random gaps before it
  task automatic send(can_item_t it);
    if (!steady && $urandom_range(99) < 29) begin
      in_valid = 0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_func = it.func;
    in_table_index = it.tidx;
    in_can_id = it.id;
    in_frame_data = it.data;
    in_signal_count = it.cnt;
    in_signal_base = it.base;
    in_name_index = it.name;
    in_start_bit = it.start;
    in_bit_length = it.len;
    in_is_signed = it.sgn;
    in_scale = it.scale;
    in_offset = it.offset;
    in_valid = 1;
    do @(posedge clk); while (in_stall);
    sb.note_item(it);
    items_sent++;
    @(negedge clk);
  endtask

  // sender stays quiet until every owed average has arrived
  task automatic drain();
    in_valid = 0;
    while (sb.owed_averages.size() > 0) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we = 1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    sb.write_reg(idx, val);
    cfg_we = 0;
  endtask

  task automatic set_regs(int win, int mult, int sdiv, int odiv);
    drain();
    repeat (SETTLE) @(negedge clk); // a silent frame may still be in flight
    write_reg(CFG_AVG_WINDOW, win);
    write_reg(CFG_HASH_MULT, mult);
    write_reg(CFG_SCALE_DIV, sdiv);
    write_reg(CFG_OFFSET_DIV, odiv);
  endtask

  task automatic load_sig(int addr, can_item_t it);
    it.func = FUNC_LOAD_SIG;
    it.tidx = addr;
    send(it);
  endtask

  // definitions first, so a decoded frame never reads an unwritten entry
  task automatic setup_message(logic [ID_W-1:0] id, logic [CNT_W-1:0] cnt);
    can_item_t it;
    int n;
    it = rand_item();
    n = (cnt > SIG_NUM) ? SIG_NUM : cnt;
    for (int j = 0; j < n; j++) begin
      can_item_t d;
      d = rand_item();
      if ($urandom_range(99) < 70) begin
        d.len = $urandom_range(1, 32);
        d.start = $urandom_range(0, 64 - d.len);
      end
      load_sig((it.base + j + 1) % DEF_NUM, d);
    end
    it.func = FUNC_LOAD_MSG;
    it.id = id;
    it.cnt = cnt;
    send(it);
    if (id != 0) known_ids.push_back(id);
  endtask

  task automatic directed();
    can_item_t it, d;
    logic [ID_W-1:0] id_a;
    id_a = 29'h1FFF_FFFF;
    it = rand_item();
    it.func = FUNC_CLEAR;
    send(it);
    // message at base 511: its definitions wrap to entries 0..7
    d = rand_item();
    d.name = 11'h7FF; d.start = 0; d.len = 32; d.sgn = 1;
    d.scale = 24'hFFFFFF; d.offset = 24'hFFFFFF;
    load_sig(0, d);
    d = rand_item();
    d.name = 0; d.start = 32; d.len = 32; d.sgn = 0; d.scale = 1; d.offset = 0;
    load_sig(1, d);
    d = rand_item(); d.len = 0;                 // zero length
    load_sig(2, d);
    d = rand_item(); d.len = 63;                // length above 32
    load_sig(3, d);
    d = rand_item(); d.start = 60; d.len = 8;   // runs past the payload end
    load_sig(4, d);
    d = rand_item(); d.start = 63; d.len = 1; d.sgn = 1; d.scale = 1000;
    load_sig(5, d);
    d = rand_item(); d.start = 8; d.len = 12; d.sgn = 1; d.scale = 7; d.offset = 5;
    load_sig(6, d);
    load_sig(7, rand_item());
    it = rand_item();
    it.func = FUNC_LOAD_MSG; it.id = id_a; it.cnt = 15; it.base = 511;
    send(it);
    it.id = 0;                                  // zero id is never stored
    send(it);
    it = rand_item();
    it.func = FUNC_FRAME; it.id = id_a;
    it.data = '1;
    send(it);
    it.data = '0;
    send(it);
    it.data = 64'h8000_0000_0000_0001;
    send(it);
    it.id = 0;
    send(it);
    it.id = 29'h0123_4567;                      // unknown id
    send(it);
    // duplicate, then fill the table so the last load is dropped
    it = rand_item();
    it.func = FUNC_LOAD_MSG; it.cnt = 0;
    it.id = id_a;
    send(it);
    for (int i = 0; i < 7; i++) begin
      it.id = 29'h100 + i;
      send(it);
    end
    it.func = FUNC_FRAME;
    it.id = 29'h106;                            // dropped id, ignored
    send(it);
    it.func = FUNC_CLEAR;
    send(it);
    it.func = FUNC_FRAME; it.id = id_a;
    send(it);
  endtask

  task automatic random_phase(int count);
    can_item_t it;
    int stop, pick;
    stop = items_sent + count;
    while (items_sent < stop) begin
      pick = $urandom_range(99);
      it = rand_item();
      if (pick < 4) begin
        it.func = FUNC_CLEAR;
        send(it);
        known_ids.delete();
      end else if (pick < 18 || known_ids.size() == 0) begin
        setup_message($urandom_range(1, 29'h1FFF_FFFF), $urandom);
      end else if (pick < 22) begin
        // loads with no signals need no definitions
        it.func = FUNC_LOAD_MSG;
        it.cnt = 0;
        if ($urandom_range(1)) it.id = 0;
        else known_ids.push_back(it.id);
        send(it);
      end else begin
        it.func = FUNC_FRAME;
        if (pick < 90) it.id = known_ids[$urandom_range(known_ids.size() - 1)];
        else if (pick < 94) it.id = 0;
        case ($urandom_range(9))
          0: it.data = '0;
          1: it.data = '1;
          default: ;
        endcase
        send(it);
      end
    end
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst_n = 1;
    @(negedge clk);
    set_regs(1, 1, 1, 1);
    directed();
    set_regs(1, 65535, 16777215, 16777215);
    hold_reqs++;               // long result hold-off while frames keep coming
    random_phase(35);
    set_regs(2, 7, 1000, 1000);
    steady = 1;
    random_phase(35);
    steady = 0;
    set_regs(0, 0, 0, 0);      // a zero window and zero divisors act as one
    random_phase(15);
    drain();
    random_phase(20);
    set_regs(65535, 31, 1, 1);
    random_phase(15);
    set_regs(4, 12345, 37, 5);
    write_reg(3'd5, $urandom); // index past the register list
    random_phase(35);
    drain();
    in_valid = 0;
    repeat (SETTLE) @(negedge clk);
    $display("covered %0d input items, %0d decoded frames, %0d averages checked",
             items_sent, sb.frames_decoded, sb.checked);
    if (sb.errors == 0 && sb.owed_averages.size() == 0) begin
      $display("No mismatches found");
    end else begin
      if (sb.owed_averages.size() != 0)
        $error("%0d averages never arrived", sb.owed_averages.size());
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/csda_pkg.sv
rtl/csda_div.sv
rtl/csda_dp.sv
rtl/csda_ctrl.sv
rtl/can_signal_decode_average.sv
tb/tb_can_signal_decode_average.sv
